// File: design/toeq_pkg.sv
// ----------------------------------------------------------------------------
// toeq_pkg: shared types for the time-ordered event queue
// Holds the event entry type, the channel beat types, the command and status
// codes, and the control bundle that fans out to every queue cell.
// ----------------------------------------------------------------------------
package toeq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [30:0]        event_time;
        logic [7:0]         event_kind;
        logic signed [31:0] event_data_a;
        logic signed [31:0] event_data_b;
    } entry_t;

    typedef struct packed
    {
        command_t           command;
        logic [30:0]        event_time;
        logic [7:0]         event_kind;
        logic signed [31:0] event_data_a;
        logic signed [31:0] event_data_b;
    } req_beat_t;

    typedef struct packed
    {
        status_t            status;
        logic [30:0]        out_time;
        logic [7:0]         out_kind;
        logic signed [31:0] out_data_a;
        logic signed [31:0] out_data_b;
        logic               now_empty;
    } rsp_beat_t;

    // Broadcast to all cells in the cycle a request beat is accepted.
    typedef struct packed
    {
        logic   insert;
        logic   remove;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// File: design/time_ordered_event_queue.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue: sorted future-event list
// Stable priority queue of timed events built as a chain of slot cells.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH events sorted by ascending time, with
// equal times leaving in arrival order. Each request beat either inserts an
// event or removes the earliest one, and every request gives exactly one
// response beat from the output register in the cycle after it is accepted.
// Every cell compares its own time against the broadcast key and shifts by
// at most one place, so the chain of cells sets a sustained rate of one
// request per cycle while the response side keeps ready high. A new
// request is taken when the output register is empty or in the same cycle
// that the previous response beat is accepted. Removal from an empty queue
// reports STATUS_EMPTY and an insert into a full queue reports STATUS_FULL
// and drops the event.
module time_ordered_event_queue
    import toeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_beat_t rsp
);

    entry_t     cell_entry [QUEUE_DEPTH];
    logic       cell_valid [QUEUE_DEPTH];
    logic       cell_goes  [QUEUE_DEPTH];
    cell_ctrl_t ctrl;
    logic       accept;
    logic       full;
    logic       empty;

    rsp_beat_t  rsp_reg;
    rsp_beat_t  rsp_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = cell_valid[QUEUE_DEPTH-1];
    assign empty     = !cell_valid[0];

    always_comb
    begin
        ctrl.insert                 = accept && (req.command == CMD_INSERT) && !full;
        ctrl.remove                 = accept && (req.command == CMD_REMOVE) && !empty;
        ctrl.new_entry.event_time   = req.event_time;
        ctrl.new_entry.event_kind   = req.event_kind;
        ctrl.new_entry.event_data_a = req.event_data_a;
        ctrl.new_entry.event_data_b = req.event_data_b;
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            entry_t left_entry;
            logic   left_valid;
            logic   left_goes;
            entry_t right_entry;
            logic   right_valid;

            if (i == 0)
            begin : g_head
                // The head cell takes the new event whenever its own entry
                // does not stay ahead of it.
                assign left_entry = '0;
                assign left_valid = 1'b0;
                assign left_goes  = 1'b1;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[i-1];
                assign left_valid = cell_valid[i-1];
                assign left_goes  = cell_goes[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_entry = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[i+1];
                assign right_valid = cell_valid[i+1];
            end

            toeq_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_entry  (left_entry),
                .left_valid  (left_valid),
                .left_goes   (left_goes),
                .right_entry (right_entry),
                .right_valid (right_valid),
                .entry       (cell_entry[i]),
                .valid       (cell_valid[i]),
                .goes        (cell_goes[i])
            );
        end
    endgenerate

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            if (req.command == CMD_INSERT)
            begin
                rsp_next.status    = full ? STATUS_FULL : STATUS_DONE;
                rsp_next.now_empty = 1'b0;
            end
            else if (empty)
            begin
                rsp_next.status    = STATUS_EMPTY;
                rsp_next.now_empty = 1'b1;
            end
            else
            begin
                rsp_next.status     = STATUS_DONE;
                rsp_next.out_time   = cell_entry[0].event_time;
                rsp_next.out_kind   = cell_entry[0].event_kind;
                rsp_next.out_data_a = cell_entry[0].event_data_a;
                rsp_next.out_data_b = cell_entry[0].event_data_b;
                rsp_next.now_empty  = !cell_valid[1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: design/toeq_cell.sv
// ----------------------------------------------------------------------------
// toeq_cell: one slot of the sorted event chain
// Holds one entry and its valid bit. On an insert it keeps its entry, takes
// the new event, or takes its left neighbor's entry; on a removal it takes
// its right neighbor's entry.
// ----------------------------------------------------------------------------
module toeq_cell
    import toeq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     left_entry,
    input  logic       left_valid,
    input  logic       left_goes,
    input  entry_t     right_entry,
    input  logic       right_valid,
    output entry_t     entry,
    output logic       valid,
    output logic       goes
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    // The stored event stays ahead of the new one when its time is not later,
    // which keeps events with equal times in arrival order.
    assign goes = valid_reg && (entry_reg.event_time <= ctrl.new_entry.event_time);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (goes)
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
            else if (left_goes)
            begin
                entry_next = ctrl.new_entry;
                valid_next = 1'b1;
            end
            else
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
        end
        else if (ctrl.remove)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule
